>>> design/lmrs_pkg.sv
// shared constants and types of the led matrix row scanner
`timescale 1ns / 1ps

package lmrs_pkg;

  // default geometry of the frame store
  localparam int ROW_COUNT     = 7;
  localparam int WORDS_PER_ROW = 5;
  localparam int WORD_BITS     = 16;

  // fixed widths of the beat fields
  localparam int ROW_FIELD_W  = 3;
  localparam int COL_FIELD_W  = 3;
  localparam int PIXEL_W      = 16;
  localparam int ROW_SEL_W    = 7;
  localparam int POS_FIELD_W  = 3;

  // item kinds carried in the mode field
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  // commands from controller to datapath
  typedef struct packed {
    logic wr_en;    // store the input word
    logic rd_en;    // read one word pair and load the result register
    logic rd_last;  // this read is the last of the row
  } lmrs_cmd_t;

endpackage

>>> design/lmrs_if.sv
// handshake channels of the led matrix row scanner
`timescale 1ns / 1ps

interface lmrs_in_if;
  logic                            valid;
  logic                            ready;
  logic                            mode;
  logic                            half;
  logic [lmrs_pkg::ROW_FIELD_W-1:0] row;
  logic [lmrs_pkg::COL_FIELD_W-1:0] column;
  logic [lmrs_pkg::PIXEL_W-1:0]     pixel_word;

  modport source (output valid, mode, half, row, column, pixel_word, input ready);
  modport sink   (input valid, mode, half, row, column, pixel_word, output ready);
endinterface

interface lmrs_out_if;
  logic                             valid;
  logic                             ready;
  logic [lmrs_pkg::ROW_SEL_W-1:0]   row_select;
  logic [lmrs_pkg::PIXEL_W-1:0]     top_word;
  logic [lmrs_pkg::PIXEL_W-1:0]     bottom_word;
  logic [lmrs_pkg::POS_FIELD_W-1:0] word_position;
  logic                             latch_strobe;

  modport source (output valid, row_select, top_word, bottom_word, word_position,
                  latch_strobe, input ready);
  modport sink   (input valid, row_select, top_word, bottom_word, word_position,
                  latch_strobe, output ready);
endinterface

>>> design/led_matrix_row_scanner.sv
// A tick beat starts a scan; its first word beat is valid once the first read loads the result.
// A scan makes WORDS_PER_ROW reads, one frame store read a cycle while the result slot is free
// or being emptied; no beat is taken in a scan. A write beat lets the next follow at once.
// Reset (rst_n low, synchronous) clears the scan row, the controller and the written flags,
// so every frame store word reads zero until written.
`timescale 1ns / 1ps

module led_matrix_row_scanner #(
  parameter int ROW_COUNT     = lmrs_pkg::ROW_COUNT,
  parameter int WORDS_PER_ROW = lmrs_pkg::WORDS_PER_ROW,
  parameter int WORD_BITS     = lmrs_pkg::WORD_BITS,
  localparam int COL_W = (WORDS_PER_ROW > 1) ? $clog2(WORDS_PER_ROW) : 1
) (
  input  logic         clk,
  input  logic         rst_n,
  lmrs_in_if.sink      in_ch,
  lmrs_out_if.source   out_ch
);

  lmrs_pkg::lmrs_cmd_t cmd;
  logic [COL_W-1:0]    rd_col;

  // sequencing of beats and reads
  lmrs_ctrl #(
    .WORDS_PER_ROW (WORDS_PER_ROW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_mode   (in_ch.mode),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .rd_col    (rd_col)
  );

  // frame store and result register
  lmrs_datapath #(
    .ROW_COUNT     (ROW_COUNT),
    .WORDS_PER_ROW (WORDS_PER_ROW),
    .WORD_BITS     (WORD_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .rd_col            (rd_col),
    .in_half           (in_ch.half),
    .in_row            (in_ch.row),
    .in_column         (in_ch.column),
    .in_pixel_word     (in_ch.pixel_word),
    .out_row_select    (out_ch.row_select),
    .out_top_word      (out_ch.top_word),
    .out_bottom_word   (out_ch.bottom_word),
    .out_word_position (out_ch.word_position),
    .out_latch_strobe  (out_ch.latch_strobe)
  );

endmodule

>>> design/lmrs_ctrl.sv
// controller: accepts beats, sequences the word reads of a tick
`timescale 1ns / 1ps

module lmrs_ctrl #(
  parameter int WORDS_PER_ROW = lmrs_pkg::WORDS_PER_ROW,
  localparam int COL_W = (WORDS_PER_ROW > 1) ? $clog2(WORDS_PER_ROW) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_mode,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output lmrs_pkg::lmrs_cmd_t   cmd,
  output logic [COL_W-1:0]      rd_col
);

  typedef enum logic [0:0] {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t           state_r, state_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             advance;
  logic             in_take;
  logic             col_last;

  // result slot is free or being emptied this cycle
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);
  assign in_take  = in_valid && in_ready;
  assign col_last = (32'(col_r) == WORDS_PER_ROW - 1);

  assign out_valid = out_valid_r;
  assign rd_col    = col_r;

  // commands to the datapath
  always_comb begin
    cmd.wr_en   = in_take && (in_mode == lmrs_pkg::MODE_WRITE);
    cmd.rd_en   = (state_r == S_SCAN) && advance;
    cmd.rd_last = (state_r == S_SCAN) && col_last;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    col_nxt   = col_r;
    case (state_r)
      S_IDLE: begin
        if (in_take && (in_mode == lmrs_pkg::MODE_TICK)) begin
          state_nxt = S_SCAN;
          col_nxt   = '0;
        end
      end
      S_SCAN: begin
        if (advance) begin
          col_nxt = col_r + 1'b1;
          if (col_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (cmd.rd_en) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // every read fills the result register
  a_rd_fills: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |=> out_valid_r)
    else $error("read did not raise the result valid");

  // the last read of a row ends the scan
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en && cmd.rd_last |=> state_r == S_IDLE)
    else $error("scan did not end after the last word");

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !cmd.rd_en)
    else $error("result overwritten while stalled");

  // stores only happen outside a scan
  a_wr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_en |-> state_r == S_IDLE && !cmd.rd_en)
    else $error("store during a scan");
`endif

endmodule

>>> design/lmrs_datapath.sv
// datapath: frame store halves, scan row, result register
`timescale 1ns / 1ps

module lmrs_datapath #(
  parameter int ROW_COUNT     = lmrs_pkg::ROW_COUNT,
  parameter int WORDS_PER_ROW = lmrs_pkg::WORDS_PER_ROW,
  parameter int WORD_BITS     = lmrs_pkg::WORD_BITS,
  localparam int COL_W      = (WORDS_PER_ROW > 1) ? $clog2(WORDS_PER_ROW) : 1,
  localparam int ROW_W      = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1,
  localparam int HALF_DEPTH = ROW_COUNT * WORDS_PER_ROW,
  localparam int ADDR_W     = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  lmrs_pkg::lmrs_cmd_t                cmd,
  input  logic [COL_W-1:0]                   rd_col,
  input  logic                               in_half,
  input  logic [lmrs_pkg::ROW_FIELD_W-1:0]   in_row,
  input  logic [lmrs_pkg::COL_FIELD_W-1:0]   in_column,
  input  logic [lmrs_pkg::PIXEL_W-1:0]       in_pixel_word,
  output logic [lmrs_pkg::ROW_SEL_W-1:0]     out_row_select,
  output logic [lmrs_pkg::PIXEL_W-1:0]       out_top_word,
  output logic [lmrs_pkg::PIXEL_W-1:0]       out_bottom_word,
  output logic [lmrs_pkg::POS_FIELD_W-1:0]   out_word_position,
  output logic                               out_latch_strobe
);

  logic [WORD_BITS-1:0] top_mem [HALF_DEPTH];
  logic [WORD_BITS-1:0] bot_mem [HALF_DEPTH];
  logic [HALF_DEPTH-1:0] top_vld_r;
  logic [HALF_DEPTH-1:0] bot_vld_r;

  logic [ROW_W-1:0]     scan_row_r;
  logic [WORD_BITS-1:0] top_data_r;
  logic [WORD_BITS-1:0] bot_data_r;
  logic                 top_hit_r;
  logic                 bot_hit_r;
  logic [lmrs_pkg::ROW_SEL_W-1:0]   row_sel_r, row_sel_nxt;
  logic [lmrs_pkg::POS_FIELD_W-1:0] pos_r;
  logic                 latch_r;

  logic                 wr_ok;
  logic                 wr_top;
  logic                 wr_bot;
  logic [ADDR_W-1:0]    wr_addr;
  logic [ADDR_W-1:0]    rd_addr;
  logic [WORD_BITS-1:0] wr_data;

  // write address and range check
  assign wr_ok   = (32'(in_row) < ROW_COUNT) && (32'(in_column) < WORDS_PER_ROW);
  assign wr_top  = cmd.wr_en && wr_ok && !in_half;
  assign wr_bot  = cmd.wr_en && wr_ok && in_half;
  assign wr_addr = ADDR_W'(32'(in_row) * WORDS_PER_ROW + 32'(in_column));
  assign wr_data = WORD_BITS'(in_pixel_word);

  // read address of the current column in the scan row
  assign rd_addr = ADDR_W'(32'(scan_row_r) * WORDS_PER_ROW + 32'(rd_col));

  // one-hot row select of the scan row
  always_comb begin
    for (int i = 0; i < lmrs_pkg::ROW_SEL_W; i++) begin
      row_sel_nxt[i] = (32'(scan_row_r) == i);
    end
  end

  // frame store halves, registered reads
  always_ff @(posedge clk) begin
    if (wr_top) begin
      top_mem[wr_addr] <= wr_data;
    end
    if (wr_bot) begin
      bot_mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      top_data_r <= top_mem[rd_addr];
      bot_data_r <= bot_mem[rd_addr];
    end
  end

  // written flags, cleared at reset so unwritten words read zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_vld_r <= '0;
      bot_vld_r <= '0;
      top_hit_r <= 1'b0;
      bot_hit_r <= 1'b0;
    end else begin
      if (wr_top) begin
        top_vld_r[wr_addr] <= 1'b1;
      end
      if (wr_bot) begin
        bot_vld_r[wr_addr] <= 1'b1;
      end
      if (cmd.rd_en) begin
        top_hit_r <= top_vld_r[rd_addr];
        bot_hit_r <= bot_vld_r[rd_addr];
      end
    end
  end

  // scan row advances after the last word of a tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_row_r <= '0;
    end else if (cmd.rd_en && cmd.rd_last) begin
      if (32'(scan_row_r) + 1 >= ROW_COUNT) begin
        scan_row_r <= '0;
      end else begin
        scan_row_r <= scan_row_r + 1'b1;
      end
    end
  end

  // result beat side fields
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      row_sel_r <= row_sel_nxt;
      pos_r     <= lmrs_pkg::POS_FIELD_W'(rd_col);
      latch_r   <= cmd.rd_last;
    end
  end

  assign out_row_select    = row_sel_r;
  assign out_top_word      = top_hit_r ? lmrs_pkg::PIXEL_W'(top_data_r) : '0;
  assign out_bottom_word   = bot_hit_r ? lmrs_pkg::PIXEL_W'(bot_data_r) : '0;
  assign out_word_position = pos_r;
  assign out_latch_strobe  = latch_r;

endmodule
